// File: hw/rtl/smpq_pkg.sv
// Package for the sorted max priority queue: field widths, codes, word types
// and the control word shared by the chain of cells.
// Depends on nothing; smpq_cell, the top level and the bench use it.
package smpq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int ACTION_W      = 2;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      status_type                status;
      logic [COUNT_W-1:0]        count_held;
   } rsp_word_type;

   // Shift command broadcast to every cell at once
   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/smpq_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Used for both channels of the sorted max priority queue; no dependencies.
interface smpq_stream_if #(
   parameter type word_type = logic
) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/smpq_cell.sv
// One position of the sorted store: holds an entry, compares it with the
// incoming value and shifts with its neighbours. Depends on smpq_pkg.
module smpq_cell #(
   parameter int OCC_W = 7,
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  smpq_pkg::cell_ctrl_type            ctrl,
   input  logic [OCC_W-1:0]                   occupancy,
   input  logic signed [smpq_pkg::VALUE_W-1:0] new_value,
   input  logic signed [smpq_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [smpq_pkg::VALUE_W-1:0] right_entry,
   input  logic                               left_ge,
   output logic signed [smpq_pkg::VALUE_W-1:0] entry,
   output logic                               ge
);

   logic signed [smpq_pkg::VALUE_W-1:0] entry_ff;
   logic signed [smpq_pkg::VALUE_W-1:0] entry_in;

   // Held entries at or above the new value stay put; equal values keep order
   assign ge    = (OCC_W'(INDEX) < occupancy) && (entry_ff >= new_value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en) begin
         if (!ge) begin
            entry_in = left_ge ? new_value : left_entry;
         end
      end else if (ctrl.remove_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hw/rtl/sorted_max_priority_queue.sv
// Sorted max priority queue: a chain of DEPTH cells kept in descending order.
// Channels: req_chan takes words of {action, value}; action insert places
// value in order, remove takes out the largest entry, clear empties the store.
// rsp_chan gives one word per request: removed_value (zero unless a remove
// succeeded), status (ok, empty on remove, full on insert) and count_held.
// An insert into a full store is dropped with status full.
// The response is registered, shown in the cycle after acceptance; one request
// per cycle unless the receiver stalls. Every cell compares its entry with the
// new value and shifts in the same cycle, so the chain never iterates.
// The cycle is set by one 32-bit compare per cell plus the shift select.
// Reset clears the occupancy count and the response valid flag; entry
// contents are left as they are and never read beyond the count.
// When the receiver stalls, the response word holds and req_chan.ready stays
// low until it is taken; a request is taken in the same cycle the pending
// response leaves.
// Depends on smpq_pkg, smpq_stream_if and smpq_cell.
module sorted_max_priority_queue #(
   parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   smpq_stream_if.sink   req_chan,
   smpq_stream_if.source rsp_chan
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   logic [OCC_W-1:0]              occ_ff;
   logic [OCC_W-1:0]              occ_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   smpq_pkg::rsp_word_type        rsp_word_ff;
   smpq_pkg::rsp_word_type        rsp_word_in;
   smpq_pkg::cell_ctrl_type       ctrl;
   smpq_pkg::req_word_type        req_word;
   logic                          accept;
   logic                          is_full;
   logic                          is_empty;
   logic signed [smpq_pkg::VALUE_W-1:0] entry [DEPTH];
   logic [DEPTH-1:0]              ge_vec;

   assign req_word       = req_chan.data;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_full        = (occ_ff == OCC_W'(DEPTH));
   assign is_empty       = (occ_ff == '0);

   assign ctrl.insert_en = accept && (req_word.action == smpq_pkg::ACT_INSERT) && !is_full;
   assign ctrl.remove_en = accept && (req_word.action == smpq_pkg::ACT_REMOVE) && !is_empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [smpq_pkg::VALUE_W-1:0] left_entry;
      logic signed [smpq_pkg::VALUE_W-1:0] right_entry;
      logic                                left_ge;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_ge    = 1'b1;
      end else begin : g_body
         assign left_entry = entry[i-1];
         assign left_ge    = ge_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      smpq_cell #(
         .OCC_W (OCC_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupancy   (occ_ff),
         .new_value   (req_word.value),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_ge     (left_ge),
         .entry       (entry[i]),
         .ge          (ge_vec[i])
      );
   end

   always_comb begin
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.removed_value = '0;
         rsp_word_in.status        = smpq_pkg::STATUS_OK;
         unique case (req_word.action)
            smpq_pkg::ACT_INSERT: begin
               if (is_full) begin
                  rsp_word_in.status = smpq_pkg::STATUS_FULL;
               end else begin
                  occ_in = occ_ff + 1'b1;
               end
            end
            smpq_pkg::ACT_REMOVE: begin
               if (is_empty) begin
                  rsp_word_in.status = smpq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_word_in.removed_value = entry[0];
                  occ_in                    = occ_ff - 1'b1;
               end
            end
            smpq_pkg::ACT_CLEAR: begin
               occ_in = '0;
            end
            default: begin
               // unused action: report the count unchanged
            end
         endcase
         rsp_word_in.count_held = smpq_pkg::COUNT_W'(occ_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("insert did not grow occupancy");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      occ_ff >= OCC_W'(2) |-> entry[0] >= entry[1])
      else $error("head of store out of order");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == smpq_pkg::STATUS_FULL
      |-> rsp_word_ff.count_held == smpq_pkg::COUNT_W'(DEPTH))
      else $error("full status with store not full");

endmodule

// File: test/tb.sv
// Self-checking bench for sorted_max_priority_queue: drives request words of
// insert, remove, clear and the unused code, and checks every response word.
// Depends on smpq_pkg, smpq_stream_if and the block itself.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = smpq_pkg::DEPTH_DEFAULT;
   localparam logic [smpq_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic [smpq_pkg::VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [smpq_pkg::VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

   typedef struct {
      smpq_pkg::req_word_type word;
      bit                     drain_first;
   } pending_req_type;

   logic clock;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   smpq_pkg::req_word_type req_data  = '0;
   logic                   rsp_ready = 1'b0;

   smpq_stream_if #(.word_type(smpq_pkg::req_word_type)) req_chan ();
   smpq_stream_if #(.word_type(smpq_pkg::rsp_word_type)) rsp_chan ();

   assign req_chan.valid = req_valid;
   assign req_chan.data  = req_data;
   assign rsp_chan.ready = rsp_ready;

   sorted_max_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pending_req_type                     request_queue[$];
   smpq_pkg::rsp_word_type              expected_rsp[$];
   logic signed [smpq_pkg::VALUE_W-1:0] sorted_store[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int checked       = 0;
   int n_insert      = 0;
   int n_full        = 0;
   int n_remove      = 0;
   int n_empty       = 0;
   int n_clear       = 0;
   int n_unused      = 0;
   int peak_held     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Expected response for one accepted request word; updates the sorted store
   function automatic smpq_pkg::rsp_word_type predict_response(smpq_pkg::req_word_type word);
      smpq_pkg::rsp_word_type r;
      logic signed [smpq_pkg::VALUE_W-1:0] v;
      int pos;
      r = '0;
      r.status = smpq_pkg::STATUS_OK;
      v = word.value;
      case (word.action)
         smpq_pkg::ACT_INSERT: begin
            n_insert++;
            if (sorted_store.size() >= DEPTH) begin
               r.status = smpq_pkg::STATUS_FULL;
               n_full++;
            end else begin
               // equal values go behind those already held
               pos = 0;
               while (pos < sorted_store.size() && sorted_store[pos] >= v) pos++;
               sorted_store.insert(pos, v);
            end
         end
         smpq_pkg::ACT_REMOVE: begin
            n_remove++;
            if (sorted_store.size() == 0) begin
               r.status = smpq_pkg::STATUS_EMPTY;
               n_empty++;
            end else begin
               r.removed_value = sorted_store.pop_front();
            end
         end
         smpq_pkg::ACT_CLEAR: begin
            n_clear++;
            sorted_store.delete();
         end
         default: n_unused++;
      endcase
      if (sorted_store.size() > peak_held) peak_held = sorted_store.size();
      r.count_held = smpq_pkg::COUNT_W'(sorted_store.size());
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch %0d at %0t: %s got 0x%0h want 0x%0h", mismatches, $time, what,
               got, want);
   endtask

   task automatic queue_request(logic [smpq_pkg::ACTION_W-1:0] action,
                                logic [smpq_pkg::VALUE_W-1:0] value,
                                bit drain_first = 1'b0);
      pending_req_type p;
      p.word.action = action;
      p.word.value  = value;
      p.drain_first = drain_first;
      request_queue.push_back(p);
   endtask

   function automatic logic [smpq_pkg::VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return $urandom();
      if (pick < 8) return smpq_pkg::VALUE_W'(int'($urandom_range(0, 16)) - 8);
      if (pick == 8) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if ($urandom_range(0, 1)) return VALUE_MAX - $urandom_range(0, 3);
      return VALUE_MIN + $urandom_range(0, 3);
   endfunction

   function automatic logic [smpq_pkg::ACTION_W-1:0] mixed_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 48) return smpq_pkg::ACT_INSERT;
      if (r < 90) return smpq_pkg::ACT_REMOVE;
      if (r < 95) return smpq_pkg::ACT_CLEAR;
      return ACT_UNUSED;
   endfunction

   // One run of related requests: fill past full, drain, or a mix
   task automatic queue_burst(int kind, bit drain_first, output int n);
      int i;
      logic [smpq_pkg::ACTION_W-1:0] a;
      case (kind)
         0: n = $urandom_range(66, 72);
         1: n = $urandom_range(5, 70);
         default: n = $urandom_range(10, 30);
      endcase
      for (i = 0; i < n; i++) begin
         case (kind)
            0: a = smpq_pkg::ACT_INSERT;
            1: a = ($urandom_range(0, 9) == 0) ? smpq_pkg::ACT_INSERT : smpq_pkg::ACT_REMOVE;
            default: a = mixed_action();
         endcase
         queue_request(a, random_value(), drain_first && i == 0);
      end
   endtask

   task automatic run_phase(int snd_idle, int rcv_idle, int target);
      int made;
      int n;
      int kind;
      send_idle_pct = snd_idle;
      recv_idle_pct = rcv_idle;
      queue_burst(0, 1'b1, n);
      made = n;
      while (made < target) begin
         kind = $urandom_range(0, 9);
         kind = (kind < 2) ? 0 : (kind < 4) ? 1 : 2;
         queue_burst(kind, $urandom_range(0, 9) == 0, n);
         made += n;
      end
      while (request_queue.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin : driver
      pending_req_type item;
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_chan.ready) expected_rsp.push_back(predict_response(req_data));
         if (!req_valid || req_chan.ready) begin
            send = request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
            // hold a marked word back until every response is in
            if (send && request_queue[0].drain_first && expected_rsp.size() != 0) send = 1'b0;
            if (send) begin
               item = request_queue.pop_front();
               req_valid <= 1'b1;
               req_data  <= item.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;
   end

   always @(posedge clock) begin : monitor
      smpq_pkg::rsp_word_type got;
      smpq_pkg::rsp_word_type want;
      if (!reset && rsp_chan.valid && rsp_ready) begin
         got = rsp_chan.data;
         if (expected_rsp.size() == 0) begin
            report_mismatch("response word with none expected", got, '0);
         end else begin
            want = expected_rsp.pop_front();
            checked++;
            if (got.removed_value !== want.removed_value)
               report_mismatch("removed_value", got.removed_value, want.removed_value);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.count_held !== want.count_held)
               report_mismatch("count_held", got.count_held, want.count_held);
         end
      end
   end

   initial begin
      #5ms;
      $display("timeout with %0d words pending", request_queue.size() + expected_rsp.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, unused code, extremes, equal values, clear
      send_idle_pct = 13;
      recv_idle_pct = 84;
      queue_request(smpq_pkg::ACT_REMOVE, 32'h1234_5678, 1'b1);
      queue_request(smpq_pkg::ACT_CLEAR, '0);
      queue_request(ACT_UNUSED, 32'h5A5A_5A5A);
      queue_request(smpq_pkg::ACT_INSERT, '0);
      queue_request(smpq_pkg::ACT_INSERT, VALUE_MAX);
      queue_request(smpq_pkg::ACT_INSERT, VALUE_MIN);
      queue_request(smpq_pkg::ACT_INSERT, '1);
      queue_request(smpq_pkg::ACT_INSERT, 32'd1);
      queue_request(smpq_pkg::ACT_INSERT, 32'd7);
      queue_request(smpq_pkg::ACT_INSERT, 32'd7);
      queue_request(ACT_UNUSED, '1);
      queue_request(smpq_pkg::ACT_REMOVE, '0);
      queue_request(smpq_pkg::ACT_REMOVE, VALUE_MAX);
      queue_request(smpq_pkg::ACT_REMOVE, '1);
      queue_request(smpq_pkg::ACT_INSERT, '1);
      queue_request(smpq_pkg::ACT_CLEAR, VALUE_MAX);
      queue_request(smpq_pkg::ACT_REMOVE, '0);
      queue_request(smpq_pkg::ACT_INSERT, VALUE_MIN);
      queue_request(smpq_pkg::ACT_INSERT, VALUE_MIN);
      queue_request(smpq_pkg::ACT_REMOVE, '0);
      queue_request(smpq_pkg::ACT_REMOVE, '0);
      queue_request(smpq_pkg::ACT_REMOVE, '0);

      run_phase(13, 84, 175);
      run_phase(84, 13, 175);
      run_phase(0, 0, 175);

      repeat (4) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("responses never arrived", expected_rsp.size(), '0);

      $display("checked %0d responses: %0d inserts (%0d refused full), %0d removes",
               checked, n_insert, n_full, n_remove);
      $display("  (%0d on empty), %0d clears, %0d unused codes, peak held %0d of %0d",
               n_empty, n_clear, n_unused, peak_held, DEPTH);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_stream_if.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_max_priority_queue.sv
test/tb.sv
